[design/ptts_pkg.sv]
// package for the periodic task tick scheduler
// holds sizes, codes, the table entry layout and the result request type
// no dependencies
`default_nettype none

package ptts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 16;
	localparam int PERIOD_W  = 16;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_TICK = 2'd1,
		KIND_RUN  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUE  = 2'd2,
		ST_ACK  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_SCAN,
		S_FIN
	} state_t;

	// one table entry as kept in the memory
	typedef struct packed {
		logic                active;
		logic [ID_W-1:0]     ident;
		logic [PERIOD_W-1:0] reload;
		logic [PERIOD_W-1:0] countdown;
	} entry_t;

	// one result request toward the output register
	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] due_id;
		logic            last;
	} out_req_t;

endpackage

`default_nettype wire

[design/ptts_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module ptts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/ptts_outreg.sv]
// output holding register for result requests
// depends on ptts_pkg
`default_nettype none

module ptts_outreg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ptts_pkg::out_req_t req,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [ptts_pkg::ID_W-1:0] due_id,
	output logic                   last
);

	logic               valid_q;
	ptts_pkg::out_req_t data_q;

	// room when empty or when the held request leaves this cycle
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= req;
		end
	end

	assign out_valid = valid_q;
	assign status    = 2'(data_q.status);
	assign due_id    = data_q.due_id;
	assign last      = data_q.last;

endmodule

`default_nettype wire

[design/periodic_task_tick_scheduler.sv]
// top level of the periodic task tick scheduler: control, table scan, memory and output
// depends on ptts_pkg, ptts_ram and ptts_outreg
`default_nettype none

// Periodic task table of ptts_pkg::MAX_TASKS entries kept in one synchronous memory
// (id, reload period, countdown and enable packed in one word). An add request
// appends an entry and answers ok, or full when the table holds MAX_TASKS entries.
// A tick request decrements every nonzero countdown and answers acknowledged. A run
// request reports each enabled entry whose countdown is zero, in table order, and
// reloads it; last marks the final report, and with nothing due one acknowledged
// result comes back. For tick and run the scan reads one entry per cycle, unless it
// is paused, through the single read port and writes each entry back as it returns.
// A stalled output pauses the scan whenever a due report has nowhere to go. The
// input is stalled while a request is in progress; a finished result may still
// wait in the output register while the next request is taken.
module periodic_task_tick_scheduler (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     kind,
	input  wire logic [ptts_pkg::ID_W-1:0]      task_id,
	input  wire logic [ptts_pkg::PERIOD_W-1:0]  period,
	input  wire logic                           enable,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          status,
	output logic [ptts_pkg::ID_W-1:0]           due_id,
	output logic                                last
);

	localparam int EW = $bits(ptts_pkg::entry_t);

	// control state
	ptts_pkg::state_t               state_q, state_d;
	ptts_pkg::kind_t                op_q;
	ptts_pkg::status_t              resp_q;
	logic [ptts_pkg::CNT_W-1:0]     used_q;

	// scan pipeline: read issue counter and the entry returning from memory
	logic [ptts_pkg::CNT_W-1:0]     idx_q;
	logic                           ent_valid_s1;
	logic [ptts_pkg::IDX_W-1:0]     ent_idx_s1;

	// due report held back until we know whether another one follows
	logic                           pend_valid_q;
	logic [ptts_pkg::ID_W-1:0]      pend_id_q;

	// memory ports
	logic                           ram_we;
	logic [ptts_pkg::IDX_W-1:0]     ram_waddr;
	ptts_pkg::entry_t               ram_wdata;
	logic                           ram_re;
	logic [EW-1:0]                  ram_rdata;

	// output register side
	logic                           out_free;
	logic                           out_push;
	ptts_pkg::out_req_t             out_req;

	logic                           in_acc;
	logic                           table_full;
	logic                           is_run;
	ptts_pkg::entry_t               ent;
	ptts_pkg::entry_t               ent_upd;
	logic                           ent_due;
	logic                           hold;
	logic                           more;
	logic                           issue;

	assign in_stall   = (state_q != ptts_pkg::S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign table_full = (used_q == ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS));
	assign is_run     = (op_q == ptts_pkg::KIND_RUN);

	assign ent     = ptts_pkg::entry_t'(ram_rdata);
	assign ent_due = is_run && ent.active && (ent.countdown == '0);

	// a second due entry while one is pending needs room in the output register
	assign hold  = (state_q == ptts_pkg::S_SCAN) && ent_valid_s1 && ent_due
		&& pend_valid_q && !out_free;
	assign more  = (idx_q != used_q);
	assign issue = (state_q == ptts_pkg::S_SCAN) && !hold && more;

	// read-modify of the returning entry; a read never targets the entry being
	// written back since the scan only moves forward, so no forwarding is needed
	always_comb begin
		ent_upd = ent;
		if (is_run) begin
			if (ent_due) begin
				ent_upd.countdown = ent.reload;
			end
		end else if (ent.countdown != '0) begin
			ent_upd.countdown = ent.countdown - ptts_pkg::PERIOD_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptts_pkg::S_IDLE: begin
				if (in_acc) begin
					case (kind)
						ptts_pkg::KIND_TICK, ptts_pkg::KIND_RUN: state_d = ptts_pkg::S_SCAN;
						default:                                 state_d = ptts_pkg::S_RESP;
					endcase
				end
			end
			ptts_pkg::S_SCAN: begin
				if (!hold && !more) begin
					state_d = ptts_pkg::S_FIN;
				end
			end
			ptts_pkg::S_RESP, ptts_pkg::S_FIN: begin
				if (out_free) begin
					state_d = ptts_pkg::S_IDLE;
				end
			end
			default: state_d = ptts_pkg::S_IDLE;
		endcase
	end

	// outputs: memory access and result requests
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ent_idx_s1;
		ram_wdata = ent_upd;
		ram_re    = issue;
		out_push  = 1'b0;
		out_req   = '{status: ptts_pkg::ST_ACK, due_id: '0, last: 1'b1};
		case (state_q)
			ptts_pkg::S_IDLE: begin
				// append happens right at acceptance
				if (in_acc && (kind == ptts_pkg::KIND_ADD) && !table_full) begin
					ram_we    = 1'b1;
					ram_waddr = used_q[ptts_pkg::IDX_W-1:0];
					ram_wdata = '{active: enable, ident: task_id, reload: period,
						countdown: period};
				end
			end
			ptts_pkg::S_SCAN: begin
				ram_we = ent_valid_s1 && !hold;
				if (ent_valid_s1 && ent_due && pend_valid_q && out_free) begin
					out_push = 1'b1;
					out_req  = '{status: ptts_pkg::ST_DUE, due_id: pend_id_q, last: 1'b0};
				end
			end
			ptts_pkg::S_RESP: begin
				out_push = out_free;
				out_req  = '{status: resp_q, due_id: '0, last: 1'b1};
			end
			ptts_pkg::S_FIN: begin
				out_push = out_free;
				if (is_run && pend_valid_q) begin
					out_req = '{status: ptts_pkg::ST_DUE, due_id: pend_id_q, last: 1'b1};
				end
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptts_pkg::S_IDLE;
			op_q         <= ptts_pkg::KIND_ADD;
			resp_q       <= ptts_pkg::ST_ACK;
			used_q       <= '0;
			idx_q        <= '0;
			ent_valid_s1 <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				op_q         <= ptts_pkg::kind_t'(kind);
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
				ent_valid_s1 <= 1'b0;
				if (kind == ptts_pkg::KIND_ADD) begin
					if (table_full) begin
						resp_q <= ptts_pkg::ST_FULL;
					end else begin
						resp_q <= ptts_pkg::ST_OK;
						used_q <= used_q + ptts_pkg::CNT_W'(1);
					end
				end else begin
					resp_q <= ptts_pkg::ST_ACK;
				end
			end else if (state_q == ptts_pkg::S_SCAN && !hold) begin
				ent_valid_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + ptts_pkg::CNT_W'(1);
				end
				if (ent_valid_s1 && ent_due) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload of the scan pipeline
	always_ff @(posedge clk) begin
		if (issue) begin
			ent_idx_s1 <= idx_q[ptts_pkg::IDX_W-1:0];
		end
		if (state_q == ptts_pkg::S_SCAN && !hold && ent_valid_s1 && ent_due) begin
			pend_id_q <= ent.ident;
		end
	end

	ptts_ram #(
		.WIDTH (EW),
		.DEPTH (ptts_pkg::MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[ptts_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	ptts_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.req       (out_req),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.due_id    (due_id),
		.last      (last)
	);

endmodule

`default_nettype wire
